// ----- src/gcd_pkg.sv -----
// ----------------------------------------------------------------------------
// gcd_pkg: shared constants, types and functions for great_circle_distance
// Fixed-point formats, CORDIC arctangent table, gain and radian factor.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int FRACTION_BITS = 30;
    localparam int CORDIC_STAGES = 32;

    localparam int CW  = FRACTION_BITS + 3;            // CORDIC datapath width
    localparam int IW  = $clog2(CORDIC_STAGES);        // stage index width
    localparam int KW  = $clog2(FRACTION_BITS + 1);    // root digit index width
    localparam int RW  = FRACTION_BITS + 3;            // root remainder width
    localparam int PIW = $clog2(2 * FRACTION_BITS + 2);
    localparam int UW  = 34;                           // angle, 5e-8 degree units
    localparam int MW  = 31;                           // reduced angle magnitude
    localparam int DW  = 35;                           // distance width

    localparam logic signed [UW:0] TURN_UNITS         = 35'sd7200000000;
    localparam logic signed [UW:0] HALF_TURN_UNITS    = 35'sd3600000000;
    localparam logic signed [UW:0] QUARTER_TURN_UNITS = 35'sd1800000000;
    localparam logic [63:0]        HALF_TURN_U64      = 64'd3600000000;

    localparam logic [33:0]   EARTH_DIAMETER_MM = 34'd12742000000;
    localparam logic [DW-1:0] MAX_DISTANCE_MM   = 35'd20015086796;

    localparam logic [63:0] ONE_Q62 = 64'h4000_0000_0000_0000;

    typedef logic [CORDIC_STAGES-1:0][CW-1:0] t_atan_tab;

    typedef struct packed {
        logic                 valid;
        logic                 flip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } t_cordic;

    typedef struct packed {
        logic                   valid;
        logic [FRACTION_BITS:0] v;
        logic [RW-1:0]          rem;
        logic [FRACTION_BITS:0] root;
    } t_root;

    // shift-subtract divide, elaboration only
    function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem  = rem - {1'b0, den};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] mul_rs(input logic [63:0] a, input logic [63:0] b,
                                           input int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (sh - 1));
        p = p >> sh;
        return p[63:0];
    endfunction

    function automatic logic [63:0] atan_series(input logic [63:0] p0, input logic [63:0] n,
                                                input int s);
        logic [63:0] p;
        logic [63:0] sum;
        logic [63:0] t;
        logic [63:0] k;
        p   = p0;
        sum = '0;
        k   = '0;
        while (p != 64'd0) begin
            t = div_u64(p, 64'd2 * k + 64'd1);
            if (k[0]) sum = sum - t;
            else      sum = sum + t;
            if (n != 64'd0)  p = div_u64(p, n * n);
            else if (s < 64) p = p >> s;
            else             p = '0;
            k = k + 64'd1;
        end
        return sum;
    endfunction

    function automatic logic [63:0] calc_pi();
        logic [63:0] a5;
        logic [63:0] a239;
        a5   = atan_series(div_u64(ONE_Q62, 64'd5), 64'd5, 0);
        a239 = atan_series(div_u64(ONE_Q62, 64'd239), 64'd239, 0);
        return 64'd16 * a5 - 64'd4 * a239;
    endfunction

    localparam logic [63:0] PI_Q62 = calc_pi();

    function automatic t_atan_tab calc_atan_tab();
        t_atan_tab   tab;
        logic [63:0] v;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (i == 0) v = PI_Q62 >> 2;
            else        v = atan_series(ONE_Q62 >> i, 64'd0, 2 * i);
            tab[i] = CW'((v + (64'd1 << (61 - FRACTION_BITS))) >> (62 - FRACTION_BITS));
        end
        return tab;
    endfunction

    // 1/K by Newton iteration on the CORDIC gain product
    function automatic logic [CW-1:0] calc_gain_inv();
        logic [63:0] p;
        logic [63:0] y;
        logic [63:0] t;
        p = 64'd1 << 61;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (2 * i < 64) p = p + (p >> (2 * i));
        end
        y = 64'd5 << 58;
        for (int k = 0; k < 8; k++) begin
            t = mul_rs(p, mul_rs(y, y, 61), 61);
            y = mul_rs(y, 64'd3 * (64'd1 << 61) - t, 62);
        end
        return CW'((y + (64'd1 << (60 - FRACTION_BITS))) >> (61 - FRACTION_BITS));
    endfunction

    localparam t_atan_tab ATAN_TAB = calc_atan_tab();
    localparam logic signed [CW-1:0] GAIN_INV = calc_gain_inv();

    // degree-half-units to radians: z = round(|r| * RAD_FACTOR / 2^RAD_SHIFT)
    localparam int RAD_PRESHIFT = 28;
    localparam logic [63:0] RAD_FACTOR =
        ((PI_Q62 / HALF_TURN_U64) << RAD_PRESHIFT) +
        (((PI_Q62 % HALF_TURN_U64) << RAD_PRESHIFT) / HALF_TURN_U64);
    localparam int RAD_SHIFT = 62 + RAD_PRESHIFT - FRACTION_BITS;
    localparam int RAD_LO_W  = 30;
    localparam int RAD_HI_W  = 30;
    localparam logic [RAD_LO_W-1:0] RAD_LO = RAD_FACTOR[RAD_LO_W-1:0];
    localparam logic [RAD_HI_W-1:0] RAD_HI = RAD_FACTOR[RAD_LO_W+RAD_HI_W-1:RAD_LO_W];
    localparam int PPW = MW + RAD_LO_W;
    localparam int PSW = PPW + RAD_LO_W + 1;

    // signed product, rounded to nearest, ties away from zero
    function automatic logic signed [CW-1:0] smul(input logic signed [CW-1:0] a,
                                                  input logic signed [CW-1:0] b);
        logic [CW-1:0]   ma;
        logic [CW-1:0]   mb;
        logic [2*CW-1:0] p;
        logic [CW-1:0]   q;
        ma = a[CW-1] ? CW'(-a) : CW'(a);
        mb = b[CW-1] ? CW'(-b) : CW'(b);
        p  = (2*CW)'(ma) * (2*CW)'(mb);
        p  = (p + ((2*CW)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
        q  = p[CW-1:0];
        return (a[CW-1] ^ b[CW-1]) ? signed'(CW'(-q)) : signed'(q);
    endfunction

endpackage

// ----- src/great_circle_distance.sv -----
// ----------------------------------------------------------------------------
// great_circle_distance: haversine distance between two lat/lon points
// Four sine/cosine cell rows, products, two digit-serial root rows and a
// vectoring CORDIC row for atan2, then scaling to millimetres.
// ----------------------------------------------------------------------------
// Input registers, sine/cosine rows, product registers, root rows, vectoring
// row and output registers lie between acceptance and o_valid. Reset clears
// all valid flags only. Throughput: one transaction per cycle unless the output
// stalls; one skid register takes an input while the output register waits.
// ----------------------------------------------------------------------------
module great_circle_distance import gcd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [30:0]   i_first_latitude,
    input  logic [31:0]   i_first_longitude,
    input  logic [30:0]   i_second_latitude,
    input  logic [31:0]   i_second_longitude,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [DW-1:0] o_distance_mm
);

    localparam logic signed [CW:0]      ONE_S = (CW+1)'(1) << FRACTION_BITS;
    localparam logic [FRACTION_BITS:0]  ONE_U = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
    localparam int                      XW    = CW - 1 + 34;

    logic w_en;
    logic w_accept;

    logic        r_skid_valid;
    logic [30:0] r_skid_lat1;
    logic [31:0] r_skid_lon1;
    logic [30:0] r_skid_lat2;
    logic [31:0] r_skid_lon2;

    logic        r_in_valid;
    logic [30:0] r_lat1;
    logic [31:0] r_lon1;
    logic [30:0] r_lat2;
    logic [31:0] r_lon2;

    logic                 r_t1_valid;
    logic signed [UW-1:0] r_u [4];

    logic [3:0]           w_lane_valid;
    logic signed [CW-1:0] w_sin [4];
    logic signed [CW-1:0] w_cos [4];

    logic                 r_p1_valid;
    logic signed [CW-1:0] r_sh2;
    logic signed [CW-1:0] r_c12;
    logic signed [CW-1:0] r_sl2;
    logic                 r_p2_valid;
    logic signed [CW-1:0] r_sh2_d;
    logic signed [CW-1:0] r_t;
    logic                 r_p3_valid;
    logic [FRACTION_BITS:0] r_a;
    logic [FRACTION_BITS:0] r_b;

    logic signed [CW:0]     w_asum;
    logic [FRACTION_BITS:0] w_a;

    t_root   w_ra [FRACTION_BITS+2];
    t_root   w_rb [FRACTION_BITS+2];
    t_cordic w_v  [CORDIC_STAGES+1];

    logic [CW-2:0]   w_zc;
    logic            r_d1_valid;
    logic [XW-1:0]   r_prod;
    logic [XW-1:0]   w_d;
    logic            r_out_valid;
    logic [DW-1:0]   r_dist;

    assign w_en     = ~r_out_valid | ~i_stall;
    assign w_accept = i_valid & ~r_skid_valid;

    // input side: skid register absorbs one transaction during a stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
            r_in_valid   <= 1'b0;
            r_t1_valid   <= 1'b0;
        end else begin
            if (w_en) begin
                r_skid_valid <= 1'b0;
                r_in_valid   <= r_skid_valid | w_accept;
                r_t1_valid   <= r_in_valid;
            end else if (w_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!w_en && w_accept) begin
            r_skid_lat1 <= i_first_latitude;
            r_skid_lon1 <= i_first_longitude;
            r_skid_lat2 <= i_second_latitude;
            r_skid_lon2 <= i_second_longitude;
        end
        if (w_en) begin
            r_lat1 <= r_skid_valid ? r_skid_lat1 : i_first_latitude;
            r_lon1 <= r_skid_valid ? r_skid_lon1 : i_first_longitude;
            r_lat2 <= r_skid_valid ? r_skid_lat2 : i_second_latitude;
            r_lon2 <= r_skid_valid ? r_skid_lon2 : i_second_longitude;
            // half-unit angles: half differences of the haversine are exact
            r_u[0] <= {{3{r_lat2[30]}}, r_lat2} - {{3{r_lat1[30]}}, r_lat1};
            r_u[1] <= {{2{r_lon2[31]}}, r_lon2} - {{2{r_lon1[31]}}, r_lon1};
            r_u[2] <= {{2{r_lat1[30]}}, r_lat1, 1'b0};
            r_u[3] <= {{2{r_lat2[30]}}, r_lat2, 1'b0};
        end
    end

    for (genvar l = 0; l < 4; l++) begin : g_lane
        gcd_sincos u_sincos (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_t1_valid),
            .i_angle (r_u[l]),
            .o_valid (w_lane_valid[l]),
            .o_sin   (w_sin[l]),
            .o_cos   (w_cos[l])
        );
    end

    // a = sin^2(dlat/2) + cos(lat1) cos(lat2) sin^2(dlon/2), clamped to [0,1]
    assign w_asum = {r_sh2_d[CW-1], r_sh2_d} + {r_t[CW-1], r_t};

    always_comb begin
        if (w_asum < 0)          w_a = '0;
        else if (w_asum > ONE_S) w_a = ONE_U;
        else                     w_a = w_asum[FRACTION_BITS:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
            r_p3_valid <= 1'b0;
        end else if (w_en) begin
            r_p1_valid <= &w_lane_valid;
            r_p2_valid <= r_p1_valid;
            r_p3_valid <= r_p2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sh2   <= smul(w_sin[0], w_sin[0]);
            r_c12   <= smul(w_cos[2], w_cos[3]);
            r_sl2   <= smul(w_sin[1], w_sin[1]);
            r_sh2_d <= r_sh2;
            r_t     <= smul(r_c12, r_sl2);
            r_a     <= w_a;
            r_b     <= ONE_U - w_a;
        end
    end

    assign w_ra[0] = '{valid: r_p3_valid, v: r_a, rem: '0, root: '0};
    assign w_rb[0] = '{valid: r_p3_valid, v: r_b, rem: '0, root: '0};

    for (genvar j = 0; j <= FRACTION_BITS; j++) begin : g_root
        gcd_root_cell u_root_a (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_digit (KW'(FRACTION_BITS - j)),
            .i_cell  (w_ra[j]),
            .o_cell  (w_ra[j+1])
        );
        gcd_root_cell u_root_b (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_digit (KW'(FRACTION_BITS - j)),
            .i_cell  (w_rb[j]),
            .o_cell  (w_rb[j+1])
        );
    end

    // atan2(sqrt(a), sqrt(1-a))
    assign w_v[0] = '{
        valid: w_ra[FRACTION_BITS+1].valid & w_rb[FRACTION_BITS+1].valid,
        flip:  1'b0,
        x:     signed'(CW'(w_rb[FRACTION_BITS+1].root)),
        y:     signed'(CW'(w_ra[FRACTION_BITS+1].root)),
        z:     '0
    };

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_vec
        gcd_cordic_cell u_vec (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_stage  (IW'(g)),
            .i_vector (1'b1),
            .i_cell   (w_v[g]),
            .o_cell   (w_v[g+1])
        );
    end

    assign w_zc = w_v[CORDIC_STAGES].z[CW-1] ? '0 : w_v[CORDIC_STAGES].z[CW-2:0];
    assign w_d  = (r_prod + (XW'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_d1_valid  <= w_v[CORDIC_STAGES].valid;
            r_out_valid <= r_d1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= XW'(w_zc) * XW'(EARTH_DIAMETER_MM);
            r_dist <= (w_d > XW'(MAX_DISTANCE_MM)) ? MAX_DISTANCE_MM : w_d[DW-1:0];
        end
    end

    assign o_stall       = r_skid_valid;
    assign o_valid       = r_out_valid;
    assign o_distance_mm = r_dist;

    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance_mm <= MAX_DISTANCE_MM)
        else $error("distance above half circumference");

    a_terms_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p3_valid |-> ({1'b0, r_a} + {1'b0, r_b}) == {1'b0, ONE_U})
        else $error("root operands do not sum to one");

    a_skid_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !w_en) |=> r_skid_valid)
        else $error("stalled transaction not captured");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> o_valid && $stable(r_dist))
        else $error("output register moved during stall");

endmodule

// ----- src/gcd_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// gcd_cordic_cell: one CORDIC micro-rotation
// Rotation mode steers by z, vectoring mode by y; one register per cell.
// ----------------------------------------------------------------------------
module gcd_cordic_cell import gcd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [IW-1:0] i_stage,
    input  logic          i_vector,
    input  t_cordic       i_cell,
    output t_cordic       o_cell
);

    logic signed [CW-1:0] w_dx;
    logic signed [CW-1:0] w_dy;
    logic signed [CW-1:0] w_atan;
    logic                 w_rot;
    t_cordic              n_cell;

    logic                 r_valid;
    logic                 r_flip;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;

    assign w_dx   = i_cell.y >>> i_stage;
    assign w_dy   = i_cell.x >>> i_stage;
    assign w_atan = signed'(ATAN_TAB[i_stage]);
    assign w_rot  = i_vector ? i_cell.y[CW-1] : ~i_cell.z[CW-1];

    always_comb begin
        n_cell = i_cell;
        if (w_rot) begin
            n_cell.x = i_cell.x - w_dx;
            n_cell.y = i_cell.y + w_dy;
            n_cell.z = i_cell.z - w_atan;
        end else begin
            n_cell.x = i_cell.x + w_dx;
            n_cell.y = i_cell.y - w_dy;
            n_cell.z = i_cell.z + w_atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flip <= n_cell.flip;
            r_x    <= n_cell.x;
            r_y    <= n_cell.y;
            r_z    <= n_cell.z;
        end
    end

    assign o_cell = '{valid: r_valid, flip: r_flip, x: r_x, y: r_y, z: r_z};

endmodule

// ----- src/gcd_root_cell.sv -----
// ----------------------------------------------------------------------------
// gcd_root_cell: one digit of a restoring square root
// Takes the next bit pair of v * 2^F and settles one root bit.
// ----------------------------------------------------------------------------
module gcd_root_cell import gcd_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic [KW-1:0] i_digit,
    input  t_root         i_cell,
    output t_root         o_cell
);

    logic [2*FRACTION_BITS+1:0] w_wide;
    logic [PIW-1:0]             w_pos;
    logic [1:0]                 w_pair;
    logic [RW+1:0]              w_rem_n;
    logic [RW+1:0]              w_trial;
    t_root                      n_cell;

    logic                       r_valid;
    logic [FRACTION_BITS:0]     r_v;
    logic [RW-1:0]              r_rem;
    logic [FRACTION_BITS:0]     r_root;

    assign w_wide  = {1'b0, i_cell.v, {FRACTION_BITS{1'b0}}};
    assign w_pos   = PIW'({i_digit, 1'b0});
    assign w_pair  = w_wide[w_pos +: 2];
    assign w_rem_n = {i_cell.rem, w_pair};
    assign w_trial = (RW+2)'({i_cell.root, 2'b01});

    always_comb begin
        n_cell = i_cell;
        if (w_rem_n >= w_trial) begin
            n_cell.rem  = RW'(w_rem_n - w_trial);
            n_cell.root = {i_cell.root[FRACTION_BITS-1:0], 1'b1};
        end else begin
            n_cell.rem  = RW'(w_rem_n);
            n_cell.root = {i_cell.root[FRACTION_BITS-1:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v    <= n_cell.v;
            r_rem  <= n_cell.rem;
            r_root <= n_cell.root;
        end
    end

    assign o_cell = '{valid: r_valid, v: r_v, rem: r_rem, root: r_root};

endmodule

// ----- src/gcd_sincos.sv -----
// ----------------------------------------------------------------------------
// gcd_sincos: sine and cosine of an angle in 5e-8 degree units
// Quarter-turn reduction, radian scaling, then a row of rotation cells.
// ----------------------------------------------------------------------------
module gcd_sincos import gcd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [UW-1:0] i_angle,
    output logic                 o_valid,
    output logic signed [CW-1:0] o_sin,
    output logic signed [CW-1:0] o_cos
);

    logic signed [UW:0]   w_u;
    logic signed [UW:0]   w_r1;
    logic signed [UW:0]   w_r2;
    logic signed [UW:0]   w_mag;
    logic                 w_flip;
    logic [PSW-1:0]       w_sum;
    logic signed [CW-1:0] w_zmag;

    logic                 r_k1_valid;
    logic signed [UW:0]   r_r1;
    logic                 r_k2_valid;
    logic [MW-1:0]        r_mag;
    logic                 r_k2_neg;
    logic                 r_k2_flip;
    logic                 r_k3_valid;
    logic [PPW-1:0]       r_p_lo;
    logic [PPW-1:0]       r_p_hi;
    logic                 r_k3_neg;
    logic                 r_k3_flip;
    logic                 r_k4_valid;
    logic                 r_k4_flip;
    logic signed [CW-1:0] r_k4_z;
    logic                 r_out_valid;
    logic signed [CW-1:0] r_sin;
    logic signed [CW-1:0] r_cos;

    t_cordic w_c [CORDIC_STAGES+1];

    assign w_u = {i_angle[UW-1], i_angle};

    // wrap to [-half turn, half turn)
    always_comb begin
        if (w_u >= HALF_TURN_UNITS)       w_r1 = w_u - TURN_UNITS;
        else if (w_u < -HALF_TURN_UNITS)  w_r1 = w_u + TURN_UNITS;
        else                              w_r1 = w_u;
    end

    // fold into [-quarter, quarter], negating the result
    always_comb begin
        w_flip = 1'b1;
        if (r_r1 > QUARTER_TURN_UNITS)        w_r2 = r_r1 - HALF_TURN_UNITS;
        else if (r_r1 < -QUARTER_TURN_UNITS)  w_r2 = r_r1 + HALF_TURN_UNITS;
        else begin
            w_r2   = r_r1;
            w_flip = 1'b0;
        end
        w_mag = w_r2[UW] ? -w_r2 : w_r2;
    end

    assign w_sum  = (PSW'(r_p_hi) << RAD_LO_W) + PSW'(r_p_lo) +
                    (PSW'(1) << (RAD_SHIFT - 1));
    assign w_zmag = signed'(CW'(w_sum >> RAD_SHIFT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k1_valid  <= 1'b0;
            r_k2_valid  <= 1'b0;
            r_k3_valid  <= 1'b0;
            r_k4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_k1_valid  <= i_valid;
            r_k2_valid  <= r_k1_valid;
            r_k3_valid  <= r_k2_valid;
            r_k4_valid  <= r_k3_valid;
            r_out_valid <= w_c[CORDIC_STAGES].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r1      <= w_r1;
            r_mag     <= MW'(w_mag);
            r_k2_neg  <= w_r2[UW];
            r_k2_flip <= w_flip;
            r_p_lo    <= PPW'(r_mag) * PPW'(RAD_LO);
            r_p_hi    <= PPW'(r_mag) * PPW'(RAD_HI);
            r_k3_neg  <= r_k2_neg;
            r_k3_flip <= r_k2_flip;
            r_k4_flip <= r_k3_flip;
            r_k4_z    <= r_k3_neg ? -w_zmag : w_zmag;
            r_sin     <= w_c[CORDIC_STAGES].flip ? -w_c[CORDIC_STAGES].y
                                                 : w_c[CORDIC_STAGES].y;
            r_cos     <= w_c[CORDIC_STAGES].flip ? -w_c[CORDIC_STAGES].x
                                                 : w_c[CORDIC_STAGES].x;
        end
    end

    assign w_c[0] = '{valid: r_k4_valid, flip: r_k4_flip, x: GAIN_INV, y: '0, z: r_k4_z};

    for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_rot
        gcd_cordic_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (i_en),
            .i_stage  (IW'(g)),
            .i_vector (1'b0),
            .i_cell   (w_c[g]),
            .o_cell   (w_c[g+1])
        );
    end

    assign o_valid = r_out_valid;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;

endmodule

// ----- tb/great_circle_distance_test.sv -----
// ----------------------------------------------------------------------------
// great_circle_distance_test: self-checking bench for great_circle_distance
// Drives coordinate pairs through the valid/stall input, predicts each
// distance with a bit-true fixed-point haversine model and compares results
// in order. Random idling on both sides, one long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module great_circle_distance_test import gcd_pkg::*;;

    localparam longint TURN    = 64'sd7200000000;
    localparam longint HALF    = 64'sd3600000000;
    localparam longint QUARTER = 64'sd1800000000;
    localparam longint LAT_MAX = 900000000;
    localparam longint LON_MAX = 1800000000;
    localparam int     EXP_DEPTH = 2048;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    logic [30:0]   i_first_latitude;
    logic [31:0]   i_first_longitude;
    logic [30:0]   i_second_latitude;
    logic [31:0]   i_second_longitude;
    logic          o_valid;
    logic          i_stall;
    logic [DW-1:0] o_distance_mm;

    great_circle_distance dut (.*);

    // expected results, written on acceptance and read in order by the checker
    logic [DW-1:0] exp_mem [EXP_DEPTH];
    int            exp_wr;
    int            exp_rd;
    int            errors;
    bit            src_idle_en;
    bit            sink_idle_en;
    bit            hold_req;

    // fixed-point constants, derived independently with integer arithmetic
    longint unsigned pi_fix;
    longint unsigned rad_mul;
    longint          atan_fix[CORDIC_STAGES];
    longint          k_inv;

    function automatic longint unsigned mul_rnd(longint unsigned a, longint unsigned b,
                                                int sh);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = (p + (128'd1 << (sh - 1))) >> sh;
        return p[63:0];
    endfunction

    function automatic longint unsigned atan_sum(longint unsigned p, longint unsigned n,
                                                 int s);
        longint unsigned acc;
        longint unsigned k;
        acc = 0;
        k   = 0;
        while (p != 0) begin
            if (k[0]) acc = acc - p / (2 * k + 1);
            else      acc = acc + p / (2 * k + 1);
            if (n != 0)      p = p / (n * n);
            else if (s < 64) p = p >> s;
            else             p = 0;
            k++;
        end
        return acc;
    endfunction

    function automatic void build_constants();
        longint unsigned v;
        longint unsigned g;
        longint unsigned y;
        longint unsigned d;
        d      = 64'd3600000000;
        pi_fix = 16 * atan_sum((64'd1 << 62) / 5, 5, 0)
               - 4 * atan_sum((64'd1 << 62) / 239, 239, 0);
        rad_mul = ((pi_fix / d) << 28) + (((pi_fix % d) << 28) / d);
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            v = (i == 0) ? pi_fix >> 2 : atan_sum((64'd1 << 62) >> i, 0, 2 * i);
            atan_fix[i] = (v + (64'd1 << (61 - FRACTION_BITS))) >> (62 - FRACTION_BITS);
        end
        g = 64'd1 << 61;
        for (int i = 0; i < CORDIC_STAGES; i++)
            if (2 * i < 64) g = g + (g >> (2 * i));
        y = 64'd5 << 58;
        for (int k = 0; k < 8; k++)
            y = mul_rnd(y, 3 * (64'd1 << 61) - mul_rnd(g, mul_rnd(y, y, 61), 61), 62);
        k_inv = (y + (64'd1 << (60 - FRACTION_BITS))) >> (61 - FRACTION_BITS);
    endfunction

    function automatic longint fix_mul(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint          m;
        ma = a < 0 ? -a : a;
        mb = b < 0 ? -b : b;
        m  = mul_rnd(ma, mb, FRACTION_BITS);
        return ((a < 0) != (b < 0)) ? -m : m;
    endfunction

    // angle in 5e-8 degree units -> sine and cosine, Q(F)
    function automatic void rotate(longint ang, output longint s, output longint c);
        longint r;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        bit     neg;
        r   = ang % TURN;
        neg = 0;
        if (r < 0) r += TURN;
        if (r >= HALF) r -= TURN;
        if (r > QUARTER) begin
            r -= HALF;
            neg = 1;
        end else if (r < -QUARTER) begin
            r += HALF;
            neg = 1;
        end
        z = mul_rnd(r < 0 ? -r : r, rad_mul, 90 - FRACTION_BITS);
        if (r < 0) z = -z;
        x = k_inv;
        y = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_fix[i];
            end else begin
                x += dx; y -= dy; z += atan_fix[i];
            end
        end
        s = neg ? -y : y;
        c = neg ? -x : x;
    endfunction

    function automatic longint unsigned sqrt_fix(longint unsigned v);
        longint unsigned rem;
        longint unsigned rt;
        logic [1:0]      pr;
        rem = 0;
        rt  = 0;
        for (int k = FRACTION_BITS; k >= 0; k--) begin
            for (int b = 1; b >= 0; b--) begin
                int p;
                p = 2 * k + b;
                pr[b] = (p >= FRACTION_BITS) ? v[p - FRACTION_BITS] : 1'b0;
            end
            rem = (rem << 2) | pr;
            if (rem >= ((rt << 2) | 1)) begin
                rem -= (rt << 2) | 1;
                rt = (rt << 1) | 1;
            end else begin
                rt = rt << 1;
            end
        end
        return rt;
    endfunction

    function automatic logic [DW-1:0] haversine_mm(logic [30:0] la1, logic [31:0] lo1,
                                                   logic [30:0] la2, logic [31:0] lo2);
        longint one;
        longint p1;
        longint q1;
        longint p2;
        longint q2;
        longint sh;
        longint ch;
        longint sl;
        longint cl;
        longint s1;
        longint c1;
        longint s2;
        longint c2;
        longint a;
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint unsigned d;
        one = 64'sd1 << FRACTION_BITS;
        p1 = longint'(signed'(la1));
        q1 = longint'(signed'(lo1));
        p2 = longint'(signed'(la2));
        q2 = longint'(signed'(lo2));
        rotate(p2 - p1, sh, ch);
        rotate(q2 - q1, sl, cl);
        rotate(2 * p1, s1, c1);
        rotate(2 * p2, s2, c2);
        a = fix_mul(sh, sh) + fix_mul(fix_mul(c1, c2), fix_mul(sl, sl));
        if (a < 0) a = 0;
        if (a > one) a = one;
        y = sqrt_fix(a);
        x = sqrt_fix(one - a);
        z = 0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; z += atan_fix[i];
            end else begin
                x -= dx; y += dy; z -= atan_fix[i];
            end
        end
        if (z < 0) z = 0;
        d = mul_rnd(2 * z, 64'd6371000000, FRACTION_BITS);
        if (d > 64'd20015086796) d = 64'd20015086796;
        return d[DW-1:0];
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("** great_circle_distance: FAILED **");
        $finish;
    end

    // valid stays high into the next call unless an idle burst drops it
    task automatic send_coords(longint la1, longint lo1, longint la2, longint lo2);
        if (src_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        i_valid            <= 1'b1;
        i_first_latitude   <= la1[30:0];
        i_first_longitude  <= lo1[31:0];
        i_second_latitude  <= la2[30:0];
        i_second_longitude <= lo2[31:0];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        exp_mem[exp_wr % EXP_DEPTH] = haversine_mm(la1[30:0], lo1[31:0], la2[30:0],
                                                   lo2[31:0]);
        exp_wr++;
        @(negedge i_clk);
    endtask

    function automatic longint rnd_range(longint lim);
        return longint'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    // any w-bit pattern, sign-extended
    function automatic longint rnd_raw(int w);
        longint v;
        v = {$urandom, $urandom};
        return v >>> (64 - w);
    endfunction

    // sink: random stall bursts, plus one long hold-off on request
    initial begin
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (300) @(negedge i_clk);
                hold_req = 0;
                i_stall <= 1'b0;
            end else if (sink_idle_en && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 7) - 1) @(negedge i_clk);
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // result checker
    initial begin
        logic [DW-1:0] exp_d;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (exp_rd == exp_wr) begin
                    $display("%t: unexpected transaction, expected none actual %0d",
                             $realtime, o_distance_mm);
                    errors++;
                end else begin
                    exp_d = exp_mem[exp_rd % EXP_DEPTH];
                    exp_rd++;
                    if (o_distance_mm !== exp_d) begin
                        $display("%t: distance_mm mismatch, expected %0d actual %0d",
                                 $realtime, exp_d, o_distance_mm);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic test_directed();
        send_coords(0, 0, 0, 0);
        send_coords(LAT_MAX, 0, -LAT_MAX, 0);
        send_coords(0, -LON_MAX, 0, LON_MAX);
        send_coords(0, 0, 0, LON_MAX);
        send_coords(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        send_coords(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_coords(0, 0, 1, 0);
        send_coords(0, 0, 0, 1);
        send_coords(450000000, 900000000, -450000000, -900000000);
        send_coords(0, 0, 0, 1799999999);
        send_coords(1, 1, -1, -1);
        // out-of-range angles, full field extremes
        send_coords(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
        send_coords((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, -(64'sd1 << 30), -(64'sd1 << 31));
        send_coords(1200000000, 0, -1200000000, 100);
        send_coords(LAT_MAX, 0, LAT_MAX, 1234567);
        send_coords(515000000, -1200000, 488500000, 23500000);
    endtask

    task automatic test_random(int n);
        longint la1;
        longint lo1;
        longint la2;
        longint lo2;
        int     kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            la1 = rnd_range(LAT_MAX);
            lo1 = rnd_range(LON_MAX);
            if (kind < 2) begin
                la2 = la1 + rnd_range(1000);          // nearby points
                lo2 = lo1 + rnd_range(1000);
            end else if (kind == 2) begin
                la2 = -la1;                            // near-antipodal
                lo2 = lo1 + (lo1 > 0 ? -LON_MAX : LON_MAX) + rnd_range(100);
            end else if (kind == 3) begin
                la1 = rnd_raw(31);                     // any bit pattern
                lo1 = rnd_raw(32);
                la2 = rnd_raw(31);
                lo2 = rnd_raw(32);
            end else begin
                la2 = rnd_range(LAT_MAX);
                lo2 = rnd_range(LON_MAX);
            end
            send_coords(la1, lo1, la2, lo2);
        end
    endtask

    task automatic test_backpressure();
        hold_req = 1;
        test_random(200);
    endtask

    initial begin
        errors             = 0;
        exp_wr             = 0;
        exp_rd             = 0;
        src_idle_en        = 1;
        sink_idle_en       = 1;
        hold_req           = 0;
        i_rst_n            = 1'b0;
        i_valid            = 1'b0;
        i_first_latitude   = '0;
        i_first_longitude  = '0;
        i_second_latitude  = '0;
        i_second_longitude = '0;
        build_constants();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_random(600);
        test_backpressure();
        src_idle_en  = 0;
        sink_idle_en = 0;
        test_random(300);
        i_valid <= 1'b0;
        while (exp_rd != exp_wr) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (errors == 0) begin
            $display("** great_circle_distance: PASSED **");
        end else begin
            $display("** great_circle_distance: FAILED **");
        end
        $finish;
    end

endmodule

// ----- great_circle_distance.f -----
src/gcd_pkg.sv
src/gcd_cordic_cell.sv
src/gcd_root_cell.sv
src/gcd_sincos.sv
src/great_circle_distance.sv
tb/great_circle_distance_test.sv
